[hw/rtl/edfs_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// edfs_pkg
// Shared types and codes of the earliest-deadline-first job scheduler.
// -----------------------------------------------------------------------------
package edfs_pkg;

	// operation codes of an input word
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// input word
	typedef struct packed {
		logic        func;
		logic [7:0]  job_id;
		logic [31:0] deadline;
		logic [15:0] burst;
	} job_word_t;

	// result word
	typedef struct packed {
		logic [31:0] now;
		logic [7:0]  run_id;
		logic        idle;
		logic        done_res;
		logic        full_res;
	} res_word_t;

	// one entry of the slot table
	typedef struct packed {
		logic [7:0]  job;
		logic [31:0] deadline;
		logic [15:0] left;
	} slot_entry_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_WB   = 4'b0100,
		ST_RESP = 4'b1000
	} edfs_state_t;

endpackage

[hw/rtl/edfs_slot_ram.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// edfs_slot_ram
// Slot table: one write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module edfs_slot_ram #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output edfs_pkg::slot_entry_t      rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(SLOTS)-1:0]   wr_addr,
	input  edfs_pkg::slot_entry_t      wr_data
);
	import edfs_pkg::*;

	slot_entry_t mem [SLOTS];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/edfs_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// edfs_core
// Sequencer: stores arriving jobs, scans the slot table on each tick for the
// earliest live deadline, expires stale jobs and writes back the run job.
// -----------------------------------------------------------------------------
module edfs_core #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  edfs_pkg::job_word_t        item_word,
	output logic                       rslt_valid,
	input  logic                       rslt_stall,
	output edfs_pkg::res_word_t        rslt_word,
	output logic [$clog2(SLOTS)-1:0]   rd_addr,
	input  edfs_pkg::slot_entry_t      rd_data,
	output logic                       wr_en,
	output logic [$clog2(SLOTS)-1:0]   wr_addr,
	output edfs_pkg::slot_entry_t      wr_data
);
	import edfs_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] END_CNT = CNT_W'(SLOTS);

	edfs_state_t        state_q;
	logic [SLOTS-1:0]   used_q;
	logic [31:0]        time_q;
	logic [CNT_W-1:0]   issue_q;
	logic               eval_valid_s1;
	logic [IDX_W-1:0]   eval_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   pick_q;
	logic [31:0]        best_dl_q;
	logic [7:0]         best_job_q;
	logic [15:0]        best_left_q;
	res_word_t          res_q;

	logic               accept;
	logic               is_arrive;
	logic               free_any;
	logic [IDX_W-1:0]   free_idx;
	logic               store;
	logic               issue_active;
	logic               expired;
	logic               take;
	logic               last_unit;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// handshake and arrival store
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign is_arrive  = (item_word.func == FUNC_ARRIVE);
	assign store      = accept && is_arrive && (item_word.burst != 16'd0) && free_any;

	// scan read issue
	assign issue_active = (state_q == ST_SCAN) && (issue_q != END_CNT);
	assign rd_addr      = issue_q[IDX_W-1:0];

	// compare of the slot whose data has come back
	assign expired = (rd_data.deadline <= time_q);
	assign take    = eval_valid_s1 && used_q[eval_idx_s1] && !expired &&
	                 (!found_q || (rd_data.deadline < best_dl_q));
	assign last_unit = (best_left_q == 16'd1);

	// table write port: new job on arrival, decremented work on write-back
	always_comb begin
		if (state_q == ST_WB) begin
			wr_en         = found_q;
			wr_addr       = pick_q;
			wr_data.job      = best_job_q;
			wr_data.deadline = best_dl_q;
			wr_data.left     = best_left_q - 16'd1;
		end else begin
			wr_en         = store;
			wr_addr       = free_idx;
			wr_data.job      = item_word.job_id;
			wr_data.deadline = item_word.deadline;
			wr_data.left     = item_word.burst;
		end
	end

	assign rslt_valid = (state_q == ST_RESP);
	assign rslt_word  = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			time_q        <= '0;
			issue_q       <= '0;
			eval_valid_s1 <= 1'b0;
			eval_idx_s1   <= '0;
			found_q       <= 1'b0;
			pick_q        <= '0;
			best_dl_q     <= '0;
			best_job_q    <= '0;
			best_left_q   <= '0;
			res_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q.now      <= time_q;
						res_q.run_id   <= 8'd0;
						res_q.idle     <= 1'b0;
						res_q.done_res <= 1'b0;
						res_q.full_res <= is_arrive && (item_word.burst != 16'd0) &&
						                  !free_any;
						issue_q        <= '0;
						eval_valid_s1  <= 1'b0;
						found_q        <= 1'b0;
						if (store) begin
							used_q[free_idx] <= 1'b1;
						end
						state_q <= is_arrive ? ST_RESP : ST_SCAN;
					end
				end
				ST_SCAN: begin
					eval_valid_s1 <= issue_active;
					eval_idx_s1   <= issue_q[IDX_W-1:0];
					if (issue_active) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					// drop jobs whose deadline has passed
					if (eval_valid_s1 && expired) begin
						used_q[eval_idx_s1] <= 1'b0;
					end
					if (take) begin
						found_q     <= 1'b1;
						pick_q      <= eval_idx_s1;
						best_dl_q   <= rd_data.deadline;
						best_job_q  <= rd_data.job;
						best_left_q <= rd_data.left;
					end
					if (!issue_active && !eval_valid_s1) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					res_q.idle     <= !found_q;
					res_q.run_id   <= found_q ? best_job_q : 8'd0;
					res_q.done_res <= found_q && last_unit;
					if (found_q && last_unit) begin
						used_q[pick_q] <= 1'b0;
					end
					if (time_q != 32'hFFFF_FFFF) begin
						time_q <= time_q + 32'd1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rslt_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/edf_job_scheduler.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// edf_job_scheduler
// Earliest-deadline-first scheduler over a table of SLOTS job slots.
//
// Input channel job_valid / job_stall / job_word carries one word per item:
// func arrive stores the job in the lowest free slot (or flags full_res),
// func tick expires jobs with deadline <= now, runs one unit of the job with
// the earliest deadline (lowest slot on a tie) and advances time by one.
// Output channel res_valid / res_stall / res_word returns one word per item.
// From the accepting edge to res_valid, an arrive passes through the core's
// response state and the output register; a tick first runs a scan of the slot
// table, one slot per cycle through its single registered read port, and then
// a write-back. The next word is accepted once the core is back in idle after
// its result has left the core.
// One item is in work at a time; job_stall is high while it is.
// The output register lets the next item be accepted while a result waits;
// a stalled result holds, and the core then waits with its own result.
// Reset clears all slot valid bits, time and both handshakes; the table
// memory itself needs no clearing pass.
// -----------------------------------------------------------------------------
module edf_job_scheduler #(
	parameter int SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_stall,
	input  edfs_pkg::job_word_t  job_word,
	output logic                 res_valid,
	input  logic                 res_stall,
	output edfs_pkg::res_word_t  res_word
);
	import edfs_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic               core_valid;
	logic               core_stall;
	res_word_t          core_word;
	logic [IDX_W-1:0]   rd_addr;
	slot_entry_t        rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	slot_entry_t        wr_data;
	logic               out_valid_q;
	res_word_t          out_word_q;

	// slot table
	edfs_slot_ram #(
		.SLOTS (SLOTS)
	) u_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// sequencer
	edfs_core #(
		.SLOTS (SLOTS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (job_valid),
		.item_stall (job_stall),
		.item_word  (job_word),
		.rslt_valid (core_valid),
		.rslt_stall (core_stall),
		.rslt_word  (core_word),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// output register
	assign core_stall = out_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else if (!core_stall) begin
			out_valid_q <= core_valid;
			out_word_q  <= core_word;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_word_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_stall |=> job_stall)
		else $error("scheduler took a word while still working on one");

	a_idle_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.idle |->
			res_word.run_id == 8'd0 && !res_word.done_res && !res_word.full_res)
		else $error("idle tick reports a running job");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.full_res |->
			!res_word.done_res && res_word.run_id == 8'd0)
		else $error("full arrival reports a job run");

endmodule
